[rtl/williams_percent_r_core_defines.svh]
// assertion macros for the williams %r core
`ifndef WILLIAMS_PERCENT_R_CORE_DEFINES_SVH
`define WILLIAMS_PERCENT_R_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define WPR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpr assertion failed");

// next-cycle implication
`define WPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpr assertion failed");

`else

`define WPR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WPR_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/wpr_pkg.sv]
package wpr_pkg;

  localparam int PRICE_W   = 32;
  localparam int PCT_W     = 16;
  localparam int WLEN_W    = 7;
  localparam int Q_W       = 15;
  localparam int DIV_STEPS = 15;
  localparam int DIV_CNT_W = 4;

  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd14;
  localparam logic [Q_W-1:0]    SCALE_Q8 = 15'd25600;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_MISSING = 2'd1,
    ST_FILLING = 2'd2,
    ST_FLAT    = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic store;
    logic scan_start;
    logic scan_rd;
    logic calc;
    logic mul;
    logic div_step;
    logic load_out;
  } wpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_accept;
    logic present;
    logic filling;
    logic scan_last;
    logic need_div;
    logic out_free;
  } wpr_sts_t;

endpackage

[rtl/wpr_if.sv]
interface wpr_in_if import wpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] high_price;
  logic [PRICE_W-1:0] low_price;
  logic [PRICE_W-1:0] close_price;
  logic               bar_present;

  modport source (output valid, high_price, low_price, close_price, bar_present,
                  input ready);
  modport sink   (input valid, high_price, low_price, close_price, bar_present,
                  output ready);
endinterface

interface wpr_cfg_if import wpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WLEN_W-1:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

interface wpr_out_if import wpr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PCT_W-1:0] percent_r;
  logic [1:0]              status;

  modport source (output valid, percent_r, status, input ready);
  modport sink   (input valid, percent_r, status, output ready);
endinterface

[rtl/williams_percent_r_core.sv]
// williams %r oscillator core
//
// in_i carries one price bar per item: high, low and close in unsigned
// 16.16 fixed point plus bar_present. out_o returns exactly one result per
// item: percent_r, the %r value times 256 in [-25600, 0], and status
// (valid, missing input, window filling, flat range). cfg_i writes
// window_length; a write clears the bar history and is taken at once.
//
// one item is worked at a time; the next can be taken in the cycle after a
// result is loaded. a missing bar or a still-filling window skips the scan
// and the divide; a full window is scanned, and the divide runs only when
// the ratio needs it: the ring memory has one read port, so the max/min
// scan takes one entry per cycle, and the scaled quotient comes from a
// 15-step restoring divider.
//
// reset empties the history and sets window_length to 14; ring contents
// are not cleared, only entries written since the last clear are scanned.
// a finished result sits in the output register while the next item is
// accepted; if the receiver stalls, the next result waits until it drains.
`include "williams_percent_r_core_defines.svh"

module williams_percent_r_core import wpr_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpr_in_if.sink    in_i,
  wpr_cfg_if.sink   cfg_i,
  wpr_out_if.source out_o
);

  // command and status between the sequencer and the datapath
  wpr_cmd_t cmd;
  wpr_sts_t sts;

  // sequencer: accept, store, scan, ratio, divide, hand off
  wpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // rings, max/min scan, divider and the output register
  wpr_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // non-valid statuses always carry a zero value
  `WPR_ASSERT_IMP(a_zero_unless_valid, clk_i, rst_ni, out_o.valid && (out_o.status != ST_VALID), out_o.percent_r == '0)

  // result stays inside the saturation range
  `WPR_ASSERT_IMP(a_pct_range, clk_i, rst_ni, out_o.valid, ($signed(out_o.percent_r) <= 16'sd0) && ($signed(out_o.percent_r) >= -16'sd25600))

  // a waiting result is never overwritten
  `WPR_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd.load_out, sts.out_free)

  // no second item is taken right behind an accepted one
  `WPR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, sts.in_accept, !cmd.in_ready)

endmodule

[rtl/wpr_ctrl.sv]
module wpr_ctrl import wpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wpr_sts_t sts_i,
  output wpr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_accept) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store      = sts_i.present;
        cmd_o.scan_start = 1'b1;
        if (!sts_i.present || sts_i.filling) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = sts_i.need_div ? S_MUL : S_FINISH;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

[rtl/wpr_dp.sv]
module wpr_dp import wpr_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  wpr_in_if.sink   in_i,
  wpr_cfg_if.sink  cfg_i,
  wpr_out_if.source out_o,
  input  wpr_cmd_t cmd_i,
  output wpr_sts_t sts_o
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int PROD_W = PRICE_W + Q_W;

  // window register and history counters
  logic [WLEN_W-1:0] wlen_q;
  logic [CNT_W-1:0]  fill_q;
  logic [IDX_W-1:0]  slot_q;
  logic [CMP_W-1:0]  wlen_ext;
  logic [CNT_W-1:0]  eff_w;
  logic [IDX_W-1:0]  wr_slot;
  logic [CNT_W-1:0]  slot_inc;
  logic [IDX_W-1:0]  slot_nxt;
  logic [CNT_W-1:0]  fill_nxt;

  // captured item
  logic [PRICE_W-1:0] high_q, low_q, close_q;
  logic               present_q;

  // ring memory, high in the upper half
  logic [2*PRICE_W-1:0] ring_mem [WINDOW_MAX];
  logic [2*PRICE_W-1:0] rd_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     scan_addr_q;

  logic [PRICE_W-1:0] top_q, bot_q;
  logic [PRICE_W-1:0] rd_hi, rd_lo;

  // ratio
  logic               num_neg, den_neg, is_flat, trivial_zero, is_sat;
  logic [PRICE_W-1:0] num, den;
  logic [PRICE_W-1:0] num_q, den_q, rem_q;
  logic [Q_W-1:0]     dvd_q, q_q;
  logic [PROD_W-1:0]  prod;
  logic [PRICE_W:0]   trial;
  logic               trial_ge;
  status_e            stat_q;

  // result register
  logic                    out_vld_q;
  logic signed [PCT_W-1:0] pct_q;
  status_e                 out_stat_q;

  always_comb begin
    wlen_ext = CMP_W'(wlen_q);
    if (wlen_ext == '0) begin
      eff_w = CNT_W'(1);
    end else if (wlen_ext > CMP_W'(WINDOW_MAX)) begin
      eff_w = CNT_W'(WINDOW_MAX);
    end else begin
      eff_w = CNT_W'(wlen_ext);
    end
    wr_slot  = (CNT_W'(slot_q) >= eff_w) ? '0 : slot_q;
    slot_inc = CNT_W'(wr_slot) + CNT_W'(1);
    slot_nxt = (slot_inc >= eff_w) ? '0 : IDX_W'(slot_inc);
    fill_nxt = (fill_q < eff_w) ? fill_q + CNT_W'(1) : fill_q;
  end

  assign rd_hi = rd_q[2*PRICE_W-1:PRICE_W];
  assign rd_lo = rd_q[PRICE_W-1:0];

  always_comb begin
    num_neg      = close_q > top_q;
    num          = num_neg ? close_q - top_q : top_q - close_q;
    den_neg      = bot_q > top_q;
    den          = den_neg ? bot_q - top_q : top_q - bot_q;
    is_flat      = top_q == bot_q;
    trivial_zero = (num == '0) || (num_neg != den_neg);
    is_sat       = num >= den;
    prod         = PROD_W'(num_q) * PROD_W'(SCALE_Q8);
    trial        = {rem_q, dvd_q[Q_W-1]};
    trial_ge     = trial >= {1'b0, den_q};
  end

  assign in_i.ready  = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    sts_o.in_accept = in_i.valid && cmd_i.in_ready;
    sts_o.present   = present_q;
    sts_o.filling   = fill_nxt < eff_w;
    sts_o.scan_last = CNT_W'(scan_addr_q) == (eff_w - CNT_W'(1));
    sts_o.need_div  = !is_flat && !trivial_zero && !is_sat;
    sts_o.out_free  = !out_vld_q || out_o.ready;
  end

  // control state: window, counters, handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= WLEN_RST;
      fill_q    <= '0;
      slot_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        wlen_q <= cfg_i.window_length;
        fill_q <= '0;
        slot_q <= '0;
      end else if (cmd_i.store) begin
        fill_q <= fill_nxt;
        slot_q <= slot_nxt;
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      ring_mem[wr_slot] <= {high_q, low_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_q <= ring_mem[scan_addr_q];
    end
  end

  // payload, scan, divider and result registers
  always_ff @(posedge clk_i) begin
    if (sts_o.in_accept) begin
      high_q    <= in_i.high_price;
      low_q     <= in_i.low_price;
      close_q   <= in_i.close_price;
      present_q <= in_i.bar_present;
      stat_q    <= in_i.bar_present ? ST_VALID : ST_MISSING;
    end
    if (cmd_i.store && sts_o.filling) begin
      stat_q <= ST_FILLING;
    end
    if (cmd_i.scan_start) begin
      scan_addr_q <= '0;
      top_q       <= '0;
      bot_q       <= '1;
    end else begin
      if (cmd_i.scan_rd) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
      end
      if (rd_vld_q) begin
        if (rd_hi > top_q) top_q <= rd_hi;
        if (rd_lo < bot_q) bot_q <= rd_lo;
      end
    end
    if (cmd_i.calc) begin
      num_q  <= num;
      den_q  <= den;
      stat_q <= is_flat ? ST_FLAT : ST_VALID;
      q_q    <= (!trivial_zero && is_sat) ? SCALE_Q8 : '0;
    end
    if (cmd_i.mul) begin
      rem_q <= prod[PROD_W-1:Q_W];
      dvd_q <= prod[Q_W-1:0];
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? PRICE_W'(trial - {1'b0, den_q}) : trial[PRICE_W-1:0];
      dvd_q <= {dvd_q[Q_W-2:0], 1'b0};
      q_q   <= {q_q[Q_W-2:0], trial_ge};
    end
    if (cmd_i.load_out) begin
      out_stat_q <= stat_q;
      pct_q      <= (stat_q == ST_VALID) ? PCT_W'(17'd0 - 17'(q_q)) : '0;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.percent_r = pct_q;
  assign out_o.status    = out_stat_q;

endmodule
